// File: src/brb_pkg.sv
package brb_pkg;

   localparam int DEPTH          = 1024;
   localparam int MAX_READ_BURST = 64;
   localparam int ADDR_W         = $clog2(DEPTH);
   localparam int CNT_W          = 11;
   localparam int RD_W           = $clog2(MAX_READ_BURST + 1);

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] RD_MAX    = CNT_W'(MAX_READ_BURST);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_SKIP  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_SKIP  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   typedef struct packed {
      logic write;
      logic read_start;
      logic read_none;
      logic skip;
      logic clear;
      logic rd_issue;
      logic rd_emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic read_none;
      logic rd_last;
   } status_type;

endpackage

// File: src/brb_ctrl.sv
module brb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   input  brb_pkg::status_type status,
   output logic                req_stall,
   output brb_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  brb_pkg::MODE_WRITE: cmd.write = 1'b1;
                  brb_pkg::MODE_READ: begin
                     if (status.read_none) begin
                        cmd.read_none = 1'b1;
                     end else begin
                        cmd.read_start = 1'b1;
                        state_in       = ST_ISSUE;
                     end
                  end
                  brb_pkg::MODE_SKIP: cmd.skip = 1'b1;
                  default: cmd.clear = 1'b1;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.rd_emit = 1'b1;
               state_in    = status.rd_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/brb_datapath.sv
module brb_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [brb_pkg::CNT_W-1:0]  csr_wr_data,
   input  logic [7:0]                 req_data_byte,
   input  logic [brb_pkg::CNT_W-1:0]  req_request_len,
   input  logic                       req_burst_first,
   input  logic                       req_burst_last,
   input  logic                       req_all_or_nothing,
   input  brb_pkg::cmd_type           cmd,
   output brb_pkg::status_type        status,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic [brb_pkg::CNT_W-1:0]  rsp_moved_count,
   output logic [brb_pkg::CNT_W-1:0]  rsp_used_after,
   output logic [brb_pkg::CNT_W-1:0]  rsp_free_after,
   output logic                       rsp_last
);

   localparam int AW = brb_pkg::ADDR_W;
   localparam int CW = brb_pkg::CNT_W;
   localparam int RW = brb_pkg::RD_W;

   logic [7:0]    mem [brb_pkg::DEPTH];

   logic [CW-1:0] capacity_ff, capacity_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] accepted_ff, accepted_in;
   logic [RW-1:0] rd_total_ff, rd_total_in;
   logic [RW-1:0] rd_left_ff, rd_left_in;
   logic [7:0]    rdata_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    byte_ff, byte_in;
   logic [CW-1:0] moved_ff, moved_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] free_ff, free_in;
   logic          last_ff, last_in;
   logic          load;

   logic [CW-1:0] room;
   logic [CW-1:0] wr_left;
   logic          wr_store;
   logic [CW-1:0] wr_next;
   logic [CW-1:0] fill_plus;
   logic [CW-1:0] rd_clamp;
   logic [CW-1:0] rd_n;
   logic [CW-1:0] skip_n;
   logic [CW-1:0] skip_sum;
   logic [CW-1:0] rd_next;
   logic [CW-1:0] cfg_cap;

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.read_none = (rd_n == '0);
   assign status.rd_last   = (rd_left_ff == '0);

   assign room      = capacity_ff - fill_ff;
   assign fill_plus = fill_ff + CW'(1);

   always_comb begin
      if (req_burst_first) begin
         if (req_request_len > room) begin
            wr_left = req_all_or_nothing ? '0 : room;
         end else begin
            wr_left = req_request_len;
         end
      end else begin
         wr_left = left_ff;
      end
      wr_store = (wr_left != '0) && (fill_ff < capacity_ff);
      wr_next  = {1'b0, wr_idx_ff} + CW'(1);
      if (wr_next >= capacity_ff) begin
         wr_next = wr_next - capacity_ff;
      end
      rd_clamp = (req_request_len < fill_ff) ? req_request_len : fill_ff;
      rd_n     = (rd_clamp > brb_pkg::RD_MAX) ? brb_pkg::RD_MAX : rd_clamp;
      skip_n   = rd_clamp;
      skip_sum = {1'b0, rd_idx_ff} + skip_n;
      if (skip_sum >= capacity_ff) begin
         skip_sum = skip_sum - capacity_ff;
      end
      rd_next = {1'b0, rd_idx_ff} + CW'(1);
      if (rd_next >= capacity_ff) begin
         rd_next = rd_next - capacity_ff;
      end
      if (csr_wr_data == '0) begin
         cfg_cap = CW'(1);
      end else if (csr_wr_data > brb_pkg::CAP_RESET) begin
         cfg_cap = brb_pkg::CAP_RESET;
      end else begin
         cfg_cap = csr_wr_data;
      end
   end

   always_comb begin
      capacity_in = capacity_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      fill_in     = fill_ff;
      left_in     = left_ff;
      accepted_in = accepted_ff;
      rd_total_in = rd_total_ff;
      rd_left_in  = rd_left_ff;
      load        = 1'b0;
      kind_in     = kind_ff;
      byte_in     = 8'd0;
      moved_in    = '0;
      used_in     = fill_ff;
      free_in     = capacity_ff - fill_ff;
      last_in     = 1'b1;

      if (csr_wr_en) begin
         capacity_in = cfg_cap;
         rd_idx_in   = '0;
         wr_idx_in   = '0;
         fill_in     = '0;
         left_in     = '0;
         accepted_in = '0;
      end else if (cmd.write) begin
         left_in     = wr_left;
         accepted_in = req_burst_first ? '0 : accepted_ff;
         if (wr_store) begin
            wr_idx_in   = wr_next[AW-1:0];
            fill_in     = fill_plus;
            left_in     = wr_left - CW'(1);
            accepted_in = accepted_in + CW'(1);
         end
         if (req_burst_last) begin
            load     = 1'b1;
            kind_in  = brb_pkg::KIND_WRITE;
            moved_in = accepted_in;
            used_in  = fill_in;
            free_in  = capacity_ff - fill_in;
            left_in  = '0;
         end
      end else if (cmd.read_none) begin
         load    = 1'b1;
         kind_in = brb_pkg::KIND_READ;
      end else if (cmd.read_start) begin
         rd_total_in = rd_n[RW-1:0];
         rd_left_in  = rd_n[RW-1:0];
      end else if (cmd.rd_issue) begin
         rd_idx_in  = rd_next[AW-1:0];
         fill_in    = fill_ff - CW'(1);
         rd_left_in = rd_left_ff - RW'(1);
      end else if (cmd.rd_emit) begin
         load     = 1'b1;
         kind_in  = brb_pkg::KIND_READ;
         byte_in  = rdata_ff;
         moved_in = CW'(rd_total_ff);
         last_in  = (rd_left_ff == '0);
      end else if (cmd.skip) begin
         rd_idx_in = skip_sum[AW-1:0];
         fill_in   = fill_ff - skip_n;
         load      = 1'b1;
         kind_in   = brb_pkg::KIND_SKIP;
         moved_in  = skip_n;
         used_in   = fill_ff - skip_n;
         free_in   = room + skip_n;
      end else if (cmd.clear) begin
         rd_idx_in   = '0;
         wr_idx_in   = '0;
         fill_in     = '0;
         left_in     = '0;
         accepted_in = '0;
         load        = 1'b1;
         kind_in     = brb_pkg::KIND_CLEAR;
         used_in     = '0;
         free_in     = capacity_ff;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_store && !csr_wr_en) begin
         mem[wr_idx_ff] <= req_data_byte;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= brb_pkg::CAP_RESET;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         accepted_ff  <= '0;
         rd_total_ff  <= '0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         accepted_ff  <= accepted_in;
         rd_total_ff  <= rd_total_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         moved_ff <= moved_in;
         used_ff  <= used_in;
         free_ff  <= free_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_moved_count = moved_ff;
   assign rsp_used_after  = used_ff;
   assign rsp_free_after  = free_ff;
   assign rsp_last        = last_ff;

endmodule

// File: src/byte_ring_buffer_top.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  mode, data byte, length, burst flags
// rsp_      out        rsp_valid / rsp_stall  kind, byte, moved, used, free, last
// csr_      in         csr_wr_en              capacity
//
// Write, skip and clear transactions are each handled in ST_IDLE without leaving it.
// A read of n bytes is accepted in ST_IDLE; each byte needs a memory read in
// ST_ISSUE and an output register load in ST_EMIT; an empty read stays in ST_IDLE.
// Reset is synchronous; the byte memory is not cleared and needs no sweep.
// A stalled result holds in the output register, and a new request is taken
// in the cycle that register is drained.
module byte_ring_buffer_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [brb_pkg::CNT_W-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_mode,
   input  logic [7:0]                req_data_byte,
   input  logic [brb_pkg::CNT_W-1:0] req_request_len,
   input  logic                      req_burst_first,
   input  logic                      req_burst_last,
   input  logic                      req_all_or_nothing,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [brb_pkg::CNT_W-1:0] rsp_moved_count,
   output logic [brb_pkg::CNT_W-1:0] rsp_used_after,
   output logic [brb_pkg::CNT_W-1:0] rsp_free_after,
   output logic                      rsp_last
);

   brb_pkg::cmd_type    cmd;
   brb_pkg::status_type status;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   brb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_data_byte      (req_data_byte),
      .req_request_len    (req_request_len),
      .req_burst_first    (req_burst_first),
      .req_burst_last     (req_burst_last),
      .req_all_or_nothing (req_all_or_nothing),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_moved_count    (rsp_moved_count),
      .rsp_used_after     (rsp_used_after),
      .rsp_free_after     (rsp_free_after),
      .rsp_last           (rsp_last)
   );

endmodule

// File: bench/byte_ring_buffer_top_test.sv
module byte_ring_buffer_top_test;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int CW           = brb_pkg::CNT_W;
   localparam int AW           = brb_pkg::ADDR_W;

   typedef logic [CW-1:0] count_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [7:0]    data;
      logic [CW-1:0] len;
      logic          first;
      logic          last;
      logic          aon;
   } ring_req_type;

   typedef struct packed {
      logic [1:0]    kind;
      logic [7:0]    out_byte;
      logic [CW-1:0] moved;
      logic [CW-1:0] used;
      logic [CW-1:0] free;
      logic          last;
   } ring_rsp_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [CW-1:0] csr_wr_data = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [1:0]    req_mode = brb_pkg::MODE_WRITE;
   logic [7:0]    req_data_byte = '0;
   logic [CW-1:0] req_request_len = '0;
   logic          req_burst_first = 1'b0;
   logic          req_burst_last = 1'b0;
   logic          req_all_or_nothing = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_kind;
   logic [7:0]    rsp_out_byte;
   logic [CW-1:0] rsp_moved_count;
   logic [CW-1:0] rsp_used_after;
   logic [CW-1:0] rsp_free_after;
   logic          rsp_last;

   byte_ring_buffer_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_request_len    (req_request_len),
      .req_burst_first    (req_burst_first),
      .req_burst_last     (req_burst_last),
      .req_all_or_nothing (req_all_or_nothing),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_moved_count    (rsp_moved_count),
      .rsp_used_after     (rsp_used_after),
      .rsp_free_after     (rsp_free_after),
      .rsp_last           (rsp_last)
   );

   // Mirror of the buffer state.
   logic [7:0]    mirror_mem [0:brb_pkg::DEPTH-1];
   logic [AW-1:0] mirror_rd = '0;
   logic [AW-1:0] mirror_wr = '0;
   logic [CW-1:0] mirror_fill = '0;
   logic [CW-1:0] mirror_cap = brb_pkg::CAP_RESET;
   logic [CW-1:0] mirror_left = '0;
   logic [CW-1:0] mirror_taken = '0;

   ring_rsp_type ring_results_due [$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  capacity_writes = 0;
   int  cycle_count = 0;
   bit  sender_idle_on = 1'b1;
   bit  receiver_idle_on = 1'b1;
   int  rsp_hold_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                  ring_results_due.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [AW-1:0] ring_advance(logic [AW-1:0] idx, logic [CW-1:0] n);
      logic [CW:0] sum;
      sum = idx + n;
      if (sum >= mirror_cap) sum = sum - mirror_cap;
      return sum[AW-1:0];
   endfunction

   function automatic void mirror_empty();
      mirror_rd = '0;
      mirror_wr = '0;
      mirror_fill = '0;
      mirror_left = '0;
      mirror_taken = '0;
   endfunction

   function automatic void queue_result(logic [1:0] kind, logic [7:0] b,
                                        logic [CW-1:0] moved, logic last);
      ring_rsp_type r;
      r.kind = kind;
      r.out_byte = b;
      r.moved = moved;
      r.used = mirror_fill;
      r.free = mirror_cap - mirror_fill;
      r.last = last;
      ring_results_due.push_back(r);
   endfunction

   function automatic void mirror_transaction(ring_req_type t);
      logic [CW-1:0] room;
      logic [CW-1:0] n;
      case (t.mode)
         brb_pkg::MODE_WRITE: begin
            if (t.first) begin
               room = mirror_cap - mirror_fill;
               if (t.len > room) mirror_left = t.aon ? '0 : room;
               else mirror_left = t.len;
               mirror_taken = '0;
            end
            if (mirror_left != 0 && mirror_fill < mirror_cap) begin
               mirror_mem[mirror_wr] = t.data;
               mirror_wr = ring_advance(mirror_wr, count_type'(1));
               mirror_fill = mirror_fill + count_type'(1);
               mirror_left = mirror_left - count_type'(1);
               mirror_taken = mirror_taken + count_type'(1);
            end
            if (t.last) begin
               queue_result(brb_pkg::KIND_WRITE, 8'h00, mirror_taken, 1'b1);
               mirror_left = '0;
            end
         end
         brb_pkg::MODE_READ: begin
            n = t.len;
            if (n > mirror_fill) n = mirror_fill;
            if (n > brb_pkg::RD_MAX) n = brb_pkg::RD_MAX;
            if (n == 0) begin
               queue_result(brb_pkg::KIND_READ, 8'h00, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  logic [7:0] b;
                  b = mirror_mem[mirror_rd];
                  mirror_rd = ring_advance(mirror_rd, count_type'(1));
                  mirror_fill = mirror_fill - count_type'(1);
                  queue_result(brb_pkg::KIND_READ, b, n, i + 1 == n);
               end
            end
         end
         brb_pkg::MODE_SKIP: begin
            n = t.len;
            if (n > mirror_fill) n = mirror_fill;
            mirror_rd = ring_advance(mirror_rd, n);
            mirror_fill = mirror_fill - n;
            queue_result(brb_pkg::KIND_SKIP, 8'h00, n, 1'b1);
         end
         default: begin
            mirror_empty();
            queue_result(brb_pkg::KIND_CLEAR, 8'h00, '0, 1'b1);
         end
      endcase
   endfunction

   // Receiver: random stall bursts.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_hold_left <= $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string field, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      ring_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_results_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                     $time, rsp_kind, rsp_out_byte);
         end else begin
            want = ring_results_due.pop_front();
            check_field("kind", count_type'(want.kind), count_type'(rsp_kind));
            check_field("out_byte", count_type'(want.out_byte), count_type'(rsp_out_byte));
            check_field("moved_count", want.moved, rsp_moved_count);
            check_field("used_after", want.used, rsp_used_after);
            check_field("free_after", want.free, rsp_free_after);
            check_field("last", count_type'(want.last), count_type'(rsp_last));
         end
         results_checked++;
      end
   end

   task automatic send_item(ring_req_type t);
      int gap;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= t.mode;
      req_data_byte <= t.data;
      req_request_len <= t.len;
      req_burst_first <= t.first;
      req_burst_last <= t.last;
      req_all_or_nothing <= t.aon;
      do @(posedge clock); while (req_stall);
      mirror_transaction(t);
      items_sent++;
   endtask

   task automatic send_op(logic [1:0] mode, int len);
      ring_req_type t;
      t.mode = mode;
      t.data = 8'($urandom_range(0, 255));
      t.len = count_type'(len);
      t.first = 1'($urandom_range(0, 1));
      t.last = 1'($urandom_range(0, 1));
      t.aon = 1'($urandom_range(0, 1));
      send_item(t);
   endtask

   task automatic send_burst(logic [7:0] bytes [$], int declared, logic aon,
                             bit with_first, bit with_last);
      ring_req_type t;
      foreach (bytes[i]) begin
         t.mode = brb_pkg::MODE_WRITE;
         t.data = bytes[i];
         t.first = with_first && i == 0;
         t.last = with_last && i == bytes.size() - 1;
         t.len = (i == 0) ? count_type'(declared) : count_type'($urandom_range(0, 2047));
         t.aon = (i == 0) ? aon : logic'($urandom_range(0, 1));
         send_item(t);
      end
   endtask

   task automatic wait_drained(int settle);
      req_valid <= 1'b0;
      while (ring_results_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_capacity(int value);
      wait_drained(8);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count_type'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0) mirror_cap = count_type'(1);
      else if (value > brb_pkg::DEPTH) mirror_cap = brb_pkg::CAP_RESET;
      else mirror_cap = count_type'(value);
      mirror_empty();
      capacity_writes++;
   endtask

   task automatic test_write_read_extremes();
      send_burst('{8'h00, 8'hFF, 8'h5A}, 3, 1'b0, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_READ, 3);
      send_op(brb_pkg::MODE_READ, 5);
      send_burst('{8'hA5}, 1, 1'b0, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_READ, 0);
      send_op(brb_pkg::MODE_READ, 2047);
   endtask

   task automatic test_skip_and_clear();
      send_burst('{8'h11, 8'h22, 8'h33, 8'h44}, 4, 1'b1, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_SKIP, 2);
      send_op(brb_pkg::MODE_SKIP, 2047);
      send_burst('{8'h55, 8'h66}, 1024, 1'b0, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_CLEAR, 0);
      send_op(brb_pkg::MODE_READ, 1);
      // Bytes with no opening burst byte are dropped after a clear.
      send_burst('{8'h77}, 0, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_full_buffer();
      write_capacity(4);
      send_burst('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, 6, 1'b0, 1'b1, 1'b1);
      send_burst('{8'h06}, 1, 1'b0, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_READ, 1);
      send_burst('{8'h07, 8'h08}, 3, 1'b1, 1'b1, 1'b1);
      send_burst('{8'h09}, 1, 1'b1, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_READ, 64);
   endtask

   task automatic test_capacity_limits();
      write_capacity(0);
      send_burst('{8'hC3, 8'h3C}, 2, 1'b0, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_READ, 2);
      write_capacity(2047);
      send_op(brb_pkg::MODE_READ, 1);
   endtask

   task automatic test_long_read();
      logic [7:0] bytes [$];
      write_capacity(1024);
      for (int i = 0; i < 70; i++) bytes.push_back(8'($urandom_range(0, 255)));
      send_burst(bytes, 70, 1'b1, 1'b1, 1'b1);
      send_op(brb_pkg::MODE_READ, 1024);
      send_op(brb_pkg::MODE_READ, 64);
   endtask

   task automatic random_traffic(int n_items);
      int sent;
      int pick;
      int actual;
      int declared;
      logic [7:0] bytes [$];
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            actual = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 12);
            declared = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2047) : actual;
            bytes.delete();
            for (int i = 0; i < actual; i++) bytes.push_back(8'($urandom_range(0, 255)));
            send_burst(bytes, declared, logic'($urandom_range(0, 1)),
                       $urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0);
            sent += actual;
         end else begin
            if (pick < 80)
               send_op(brb_pkg::MODE_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                                      : $urandom_range(0, 70));
            else if (pick < 92)
               send_op(brb_pkg::MODE_SKIP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                                      : $urandom_range(0, 20));
            else
               send_op(brb_pkg::MODE_CLEAR, $urandom_range(0, 2047));
            sent++;
         end
      end
   endtask

   task automatic test_random_phase(int cap, int n_items, bit idling);
      write_capacity(cap);
      sender_idle_on = idling;
      receiver_idle_on = idling;
      random_traffic(n_items);
   endtask

   initial begin
      for (int i = 0; i < brb_pkg::DEPTH; i++) mirror_mem[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_write_read_extremes();
      test_skip_and_clear();
      test_full_buffer();
      test_capacity_limits();
      test_long_read();

      test_random_phase(1, 60, 1'b1);
      test_random_phase(7, 100, 1'b1);
      test_random_phase(64, 100, 1'b1);
      test_random_phase(2047, 80, 1'b1);
      test_random_phase($urandom_range(0, 2047), 80, 1'b1);
      test_random_phase(1024, 80, 1'b0);

      wait_drained(150);
      $display("Sent %0d request transactions and checked %0d result transactions,",
               items_sent, results_checked);
      $display("over %0d capacity settings from 1 byte to full depth.", capacity_writes + 1);
      if (mismatches == 0 && ring_results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
